// ----- rtl/core/pbrle_pkg.sv -----
// Shared constants and the byte-chunk type of the run-length encoder.
`default_nettype none

package pbrle_pkg;

   localparam int MAX_SEGMENT_DEF = 127;
   localparam int WORD_BYTES      = 4;
   localparam int BYTE_W          = 8;

   localparam logic [BYTE_W-1:0] LITERAL_BASE = 8'd128;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic [WORD_BYTES-1:0][BYTE_W-1:0] data;
      logic [2:0]                        count;
      logic                              last;
      logic                              done;
   } chunk_type;

endpackage

`default_nettype wire

// ----- rtl/core/pbrle_store.sv -----
// Literal byte store: one byte written per cycle, one four-byte row read per cycle.
`default_nettype none

module pbrle_store #(
   parameter int MAX_SEGMENT = pbrle_pkg::MAX_SEGMENT_DEF,
   localparam int ROWS  = (MAX_SEGMENT + 3) / 4,
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ROW_W-1:0]      wr_row,
   input  wire logic [1:0]            wr_lane,
   input  wire pbrle_pkg::byte_type   wr_byte,
   input  wire logic                  rd_en,
   input  wire logic [ROW_W-1:0]      rd_row,
   output logic [3:0][7:0]            rd_data
);
   import pbrle_pkg::*;

   logic [3:0][7:0] mem_ff [ROWS];
   logic [3:0][7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row][wr_lane] <= wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pbrle_ctrl.sv -----
// Encoder control: run and literal state, segment planning and store readout.
`default_nettype none

module pbrle_ctrl #(
   parameter int MAX_SEGMENT = pbrle_pkg::MAX_SEGMENT_DEF,
   localparam int ROWS  = (MAX_SEGMENT + 3) / 4,
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int CNT_W = ($clog2(MAX_SEGMENT + 1) > 3) ? $clog2(MAX_SEGMENT + 1) : 3
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire pbrle_pkg::byte_type   req_data_byte,
   input  wire logic                  req_end_of_stream,
   output logic                       wr_en,
   output logic [ROW_W-1:0]           wr_row,
   output logic [1:0]                 wr_lane,
   output pbrle_pkg::byte_type        wr_byte,
   output logic                       rd_en,
   output logic [ROW_W-1:0]           rd_row,
   input  wire logic [3:0][7:0]       rd_data,
   output logic                       chunk_valid,
   input  wire logic                  chunk_ready,
   output pbrle_pkg::chunk_type       chunk
);
   import pbrle_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_RUN_A = 5'b00010,
      S_HDR   = 5'b00100,
      S_DATA  = 5'b01000,
      S_RUN_B = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] lit_cnt_ff, lit_cnt_in;
   logic             in_run_ff, in_run_in;
   logic [CNT_W-1:0] run_len_ff, run_len_in;
   byte_type         run_val_ff, run_val_in;
   byte_type         hist1_ff, hist1_in, hist2_ff, hist2_in;
   logic [CNT_W-1:0] rlen_ff, rlen_in;
   byte_type         rval_ff, rval_in;
   logic [CNT_W-1:0] lit_n_ff, lit_n_in;
   logic             post_ff, post_in;
   logic             eos_ff, eos_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] iss_left_ff, iss_left_in;
   logic [ROW_W-1:0] rd_row_ff, rd_row_in;
   logic             dv_ff, dv_in;

   logic             req_fire, chunk_fire, data_take;
   logic [CNT_W-1:0] c_cnt, inc, wr_idx, iss_step;
   logic [2:0]       dcnt;
   logic             triple, match;
   logic             pre;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign chunk_fire = chunk_valid && chunk_ready;
   assign data_take  = chunk_fire && (state_ff == S_DATA);
   assign dcnt       = (left_ff >= CNT_W'(4)) ? 3'd4 : 3'(left_ff);
   assign iss_step   = (iss_left_ff >= CNT_W'(4)) ? CNT_W'(4) : iss_left_ff;

   assign rd_en  = (state_ff != S_IDLE) && (iss_left_ff != '0) && (!dv_ff || data_take);
   assign rd_row = rd_row_ff;

   always_comb begin
      chunk_valid = 1'b0;
      chunk.data  = '0;
      chunk.count = 3'd0;
      chunk.last  = 1'b0;
      unique case (state_ff)
         S_RUN_A, S_RUN_B: begin
            chunk_valid   = 1'b1;
            chunk.data[0] = 8'(rlen_ff);
            chunk.data[1] = rval_ff;
            chunk.count   = 3'd2;
            chunk.last    = (state_ff == S_RUN_B) || (lit_n_ff == '0);
         end
         S_HDR: begin
            chunk_valid   = 1'b1;
            chunk.data[0] = 8'(lit_n_ff) + LITERAL_BASE;
            chunk.count   = 3'd1;
         end
         S_DATA: begin
            chunk_valid = dv_ff;
            chunk.data  = rd_data;
            chunk.count = dcnt;
            chunk.last  = (left_ff <= CNT_W'(4)) && !post_ff;
         end
         default: begin
            chunk_valid = 1'b0;
         end
      endcase
      chunk.done = eos_ff && chunk.last;
   end

   always_comb begin
      state_in    = state_ff;
      lit_cnt_in  = lit_cnt_ff;
      in_run_in   = in_run_ff;
      run_len_in  = run_len_ff;
      run_val_in  = run_val_ff;
      hist1_in    = hist1_ff;
      hist2_in    = hist2_ff;
      rlen_in     = rlen_ff;
      rval_in     = rval_ff;
      lit_n_in    = lit_n_ff;
      post_in     = post_ff;
      eos_in      = eos_ff;
      left_in     = left_ff;
      iss_left_in = iss_left_ff;
      rd_row_in   = rd_row_ff;
      wr_en       = 1'b0;
      wr_idx      = '0;
      pre         = 1'b0;
      c_cnt       = lit_cnt_ff + CNT_W'(1);
      inc         = run_len_ff + CNT_W'(1);
      match       = (req_data_byte == run_val_ff);
      triple      = (lit_cnt_ff >= CNT_W'(2)) && (req_data_byte == hist1_ff) &&
                    (req_data_byte == hist2_ff);

      if (req_fire) begin
         lit_n_in = '0;
         post_in  = 1'b0;
         eos_in   = req_end_of_stream;
         rlen_in  = run_len_ff;
         rval_in  = run_val_ff;
         if (in_run_ff) begin
            if (match) begin
               if ((inc >= CNT_W'(MAX_SEGMENT)) || req_end_of_stream) begin
                  pre        = 1'b1;
                  rlen_in    = inc;
                  in_run_in  = 1'b0;
                  run_len_in = '0;
               end else begin
                  run_len_in = inc;
               end
            end else begin
               pre        = 1'b1;
               in_run_in  = 1'b0;
               run_len_in = '0;
               wr_en      = 1'b1;
               wr_idx     = '0;
               hist2_in   = hist1_ff;
               hist1_in   = req_data_byte;
               lit_cnt_in = CNT_W'(1);
               if (req_end_of_stream) begin
                  lit_n_in = CNT_W'(1);
               end
            end
         end else begin
            wr_en    = 1'b1;
            wr_idx   = lit_cnt_ff;
            hist2_in = hist1_ff;
            hist1_in = req_data_byte;
            if (triple) begin
               lit_n_in   = lit_cnt_ff - CNT_W'(2);
               lit_cnt_in = '0;
               in_run_in  = 1'b1;
               run_len_in = CNT_W'(3);
               run_val_in = req_data_byte;
               if ((MAX_SEGMENT <= 3) || req_end_of_stream) begin
                  post_in    = 1'b1;
                  rlen_in    = CNT_W'(3);
                  rval_in    = req_data_byte;
                  in_run_in  = 1'b0;
                  run_len_in = '0;
               end
            end else if (c_cnt >= CNT_W'(MAX_SEGMENT)) begin
               lit_n_in   = c_cnt;
               lit_cnt_in = '0;
            end else begin
               lit_cnt_in = c_cnt;
               if (req_end_of_stream) begin
                  lit_n_in = c_cnt;
               end
            end
         end
         if (req_end_of_stream) begin
            lit_cnt_in = '0;
            in_run_in  = 1'b0;
            run_len_in = '0;
            run_val_in = '0;
         end
         left_in     = lit_n_in;
         iss_left_in = lit_n_in;
         rd_row_in   = '0;
         if (pre) begin
            state_in = S_RUN_A;
         end else if (lit_n_in != '0) begin
            state_in = S_HDR;
         end else if (post_in) begin
            state_in = S_RUN_B;
         end else begin
            state_in = S_IDLE;
         end
      end else if (chunk_fire) begin
         unique case (state_ff)
            S_RUN_A: state_in = (lit_n_ff != '0) ? S_HDR : S_IDLE;
            S_HDR:   state_in = S_DATA;
            S_DATA: begin
               left_in = left_ff - CNT_W'(dcnt);
               if (left_ff <= CNT_W'(4)) begin
                  state_in = post_ff ? S_RUN_B : S_IDLE;
               end
            end
            S_RUN_B: state_in = S_IDLE;
            default: state_in = S_IDLE;
         endcase
      end

      if (rd_en) begin
         iss_left_in = iss_left_ff - iss_step;
         rd_row_in   = rd_row_ff + ROW_W'(1);
      end
      dv_in = rd_en ? 1'b1 : (data_take ? 1'b0 : dv_ff);
   end

   assign wr_row  = ROW_W'(wr_idx >> 2);
   assign wr_lane = wr_idx[1:0];
   assign wr_byte = req_data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         lit_cnt_ff  <= '0;
         in_run_ff   <= 1'b0;
         run_len_ff  <= '0;
         run_val_ff  <= '0;
         lit_n_ff    <= '0;
         post_ff     <= 1'b0;
         eos_ff      <= 1'b0;
         left_ff     <= '0;
         iss_left_ff <= '0;
         rd_row_ff   <= '0;
         dv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         lit_cnt_ff  <= lit_cnt_in;
         in_run_ff   <= in_run_in;
         run_len_ff  <= run_len_in;
         run_val_ff  <= run_val_in;
         lit_n_ff    <= lit_n_in;
         post_ff     <= post_in;
         eos_ff      <= eos_in;
         left_ff     <= left_in;
         iss_left_ff <= iss_left_in;
         rd_row_ff   <= rd_row_in;
         dv_ff       <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      hist1_ff <= hist1_in;
      hist2_ff <= hist2_in;
      rlen_ff  <= rlen_in;
      rval_ff  <= rval_in;
   end

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("Store written and read in the same cycle.");

   a_lit_cnt_range: assert property (@(posedge clock) disable iff (reset)
      lit_cnt_ff < CNT_W'(MAX_SEGMENT))
      else $error("Literal count reached the segment limit.");

   a_run_len_range: assert property (@(posedge clock) disable iff (reset)
      in_run_ff |-> (run_len_ff >= CNT_W'(3)) && (run_len_ff < CNT_W'(MAX_SEGMENT)))
      else $error("Open run has an impossible length.");

   a_no_data_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !dv_ff && (iss_left_ff == '0))
      else $error("Store readout left pending at idle.");

endmodule

`default_nettype wire

// ----- rtl/core/pbrle_pack.sv -----
// Byte packer: gathers code bytes into words and holds the result register.
`default_nettype none

module pbrle_pack (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  chunk_valid,
   output logic                       chunk_ready,
   input  wire pbrle_pkg::chunk_type  chunk,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [31:0]                rsp_code_word,
   output logic [2:0]                 rsp_byte_count,
   output logic                       rsp_burst_last,
   output logic                       rsp_stream_done
);
   import pbrle_pkg::*;

   logic [6:0][7:0] hold_ff, hold_in, shifted;
   logic [2:0]      cnt_ff, cnt_in;
   logic            fin_ff, fin_in;
   logic            done_ff, done_in;
   logic            out_valid_ff;
   logic [3:0][7:0] word_ff, word_in;
   logic [2:0]      count_ff;
   logic            last_ff, sdone_ff;

   logic            out_free, emit, take, emit_last;
   logic [2:0]      ecnt, rem, idx;

   always_comb begin
      out_free  = !out_valid_ff || rsp_ready;
      ecnt      = (cnt_ff >= 3'd4) ? 3'd4 : cnt_ff;
      emit      = out_free && ((cnt_ff >= 3'd4) || (fin_ff && (cnt_ff != 3'd0)));
      rem       = emit ? (cnt_ff - ecnt) : cnt_ff;
      emit_last = emit && fin_ff && (rem == 3'd0);
      chunk_ready = (rem <= 3'd3) && (!fin_ff || emit_last);
      take      = chunk_valid && chunk_ready;
      shifted   = emit ? (hold_ff >> {ecnt, 3'b000}) : hold_ff;
      for (int i = 0; i < 7; i++) begin
         idx = 3'(i) - rem;
         if (3'(i) < rem) begin
            hold_in[i] = shifted[i];
         end else if (take && (idx < chunk.count)) begin
            hold_in[i] = chunk.data[idx[1:0]];
         end else begin
            hold_in[i] = 8'h00;
         end
      end
      for (int j = 0; j < 4; j++) begin
         word_in[j] = (3'(j) < ecnt) ? hold_ff[j] : 8'h00;
      end
      cnt_in  = rem + (take ? chunk.count : 3'd0);
      fin_in  = take ? chunk.last : (emit_last ? 1'b0 : fin_ff);
      done_in = take ? chunk.done : done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 3'd0;
         fin_ff       <= 1'b0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (emit) begin
         word_ff  <= word_in;
         count_ff <= ecnt;
         last_ff  <= emit_last;
         sdone_ff <= emit_last && done_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_code_word   = word_ff;
   assign rsp_byte_count  = count_ff;
   assign rsp_burst_last  = last_ff;
   assign rsp_stream_done = sdone_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stream_done) |-> rsp_burst_last)
      else $error("Stream end flagged on a word that does not end its burst.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count != 3'd0) && (rsp_byte_count <= 3'd4))
      else $error("Result word carries an impossible byte count.");

   a_full_inner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_burst_last) |-> (rsp_byte_count == 3'd4))
      else $error("Word inside a burst is not full.");

   a_fin_blocks: assert property (@(posedge clock) disable iff (reset)
      (fin_ff && (cnt_ff > 3'd4)) |-> !chunk_ready)
      else $error("New burst accepted before the previous one drained.");

endmodule

`default_nettype wire

// ----- rtl/core/packbits_rle_encoder.sv -----
// Top level of the run-length encoder with 32-bit packed output words.
//
// Usage: each input word on req_ carries one raw byte and an end-of-stream flag.
// Every code byte it causes leaves on rsp_ packed four to a word, first byte in
// bits 7..0, with rsp_byte_count valid bytes; rsp_burst_last marks the last word
// of an input and rsp_stream_done the last word of a stream.
// Flow: a byte that causes no code leaves req_ready high. A run leaves as
// one two-byte code, length then value. A literal of n bytes leaves as a
// header byte and then its bytes, read row by row through the four-byte row
// read port of the literal store; a new byte is accepted once the control has
// handed every code byte of the previous one to the packer. The packer holds
// the bytes in a register and registers each result word from it.
// Reset clears the run and literal state and the output valid flag; the store
// itself needs no clearing. When the receiver stalls, the packer keeps up to
// seven bytes and the result register, then back-pressures the control, which
// holds its readout and finally req_ready.
`default_nettype none

module packbits_rle_encoder #(
   parameter int MAX_SEGMENT = pbrle_pkg::MAX_SEGMENT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_stream,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_code_word,
   output logic [2:0]       rsp_byte_count,
   output logic             rsp_burst_last,
   output logic             rsp_stream_done
);
   import pbrle_pkg::*;

   localparam int ROWS  = (MAX_SEGMENT + 3) / 4;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic             wr_en, rd_en;
   logic [ROW_W-1:0] wr_row, rd_row;
   logic [1:0]       wr_lane;
   byte_type         wr_byte;
   logic [3:0][7:0]  rd_data;
   logic             chunk_valid, chunk_ready;
   chunk_type        chunk;

   pbrle_store #(.MAX_SEGMENT(MAX_SEGMENT)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_row  (wr_row),
      .wr_lane (wr_lane),
      .wr_byte (wr_byte),
      .rd_en   (rd_en),
      .rd_row  (rd_row),
      .rd_data (rd_data)
   );

   pbrle_ctrl #(.MAX_SEGMENT(MAX_SEGMENT)) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .wr_en             (wr_en),
      .wr_row            (wr_row),
      .wr_lane           (wr_lane),
      .wr_byte           (wr_byte),
      .rd_en             (rd_en),
      .rd_row            (rd_row),
      .rd_data           (rd_data),
      .chunk_valid       (chunk_valid),
      .chunk_ready       (chunk_ready),
      .chunk             (chunk)
   );

   pbrle_pack u_pack (
      .clock           (clock),
      .reset           (reset),
      .chunk_valid     (chunk_valid),
      .chunk_ready     (chunk_ready),
      .chunk           (chunk),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_word   (rsp_code_word),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_burst_last  (rsp_burst_last),
      .rsp_stream_done (rsp_stream_done)
   );

endmodule

`default_nettype wire
